FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the interrupt controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define MIC_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every clock edge, during reset too.
`define MIC_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: sv/mic_pkg.sv
// Types, register offsets and helper functions of the interrupt controller.
package mic_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MEMRD,
        ST_SCAN,
        ST_PRIV
    } st_t;

    localparam logic [1:0] ACT_LINE  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [8:0] IDLE_NUM   = 9'h1FF;
    localparam logic [8:0] SOFT_NUM   = 9'd15;
    localparam int         CORE_WORDS = 13;
    localparam logic [3:0] BUS_SIZE   = 4'd4;

    // bitmap kinds
    localparam logic [1:0] BM_ENABLE  = 2'd0;
    localparam logic [1:0] BM_PENDING = 2'd1;
    localparam logic [1:0] BM_ACTIVE  = 2'd2;

    // distributor window
    localparam logic [14:0] D_CTRL      = 15'h000;
    localparam logic [14:0] D_STATUS    = 15'h008;
    localparam logic [14:0] D_ID        = 15'h010;
    localparam logic [14:0] D_TYPE_OFF  = 15'h080;
    localparam logic [14:0] D_CFG_OFF   = 15'h100;
    localparam logic [14:0] D_PRI_OFF   = 15'h200;
    localparam logic [14:0] D_DEST_OFF  = 15'h1000;
    localparam logic [7:0]  D_BM_GRP_LO = 8'd12;   // 0x600 in 128-byte groups
    localparam logic [7:0]  D_BM_GRP_HI = 8'd17;

    // core window
    localparam logic [14:0] C_CTRL     = 15'h00;
    localparam logic [14:0] C_ZERO_A   = 15'h08;
    localparam logic [14:0] C_TYPE     = 15'h10;
    localparam logic [14:0] C_SCFG     = 15'h14;
    localparam logic [14:0] C_PCFG     = 15'h18;
    localparam logic [14:0] C_SPRI     = 15'h20;
    localparam logic [14:0] C_PPRI     = 15'h30;
    localparam logic [14:0] C_BM_LO    = 15'h40;
    localparam logic [14:0] C_BM_HI    = 15'h54;
    localparam logic [14:0] C_SOFT     = 15'h60;
    localparam logic [14:0] C_ZERO_B   = 15'h64;
    localparam logic [14:0] C_HPPIR    = 15'h68;
    localparam logic [14:0] C_READY    = 15'h6c;
    localparam logic [14:0] C_ZERO_WIN = 15'h70;
    localparam logic [14:0] C_ZERO_C   = 15'h90;
    localparam logic [14:0] C_EN_NUM   = 15'ha0;
    localparam logic [14:0] C_DIS_NUM  = 15'ha4;
    localparam logic [14:0] C_ACK      = 15'hb4;

    // index of the lowest set bit, 31 when none is set
    function automatic logic [4:0] low_bit(input logic [31:0] v);
        logic [4:0] r;
        r = 5'd31;
        for (int k = 31; k >= 0; k--) begin
            if (v[k]) begin
                r = 5'(k);
            end
        end
        return r;
    endfunction

    // offset lies in [base, base + 4*words)
    function automatic logic in_win(input logic [14:0] o, input logic [14:0] base,
                                    input logic [15:0] words);
        logic [17:0] lim;
        lim = 18'(base) + {words, 2'b00};
        return (o >= base) && (18'(o) < lim);
    endfunction

endpackage

FILE: sv/mic_ram.sv
// Single-port setting-word memory with registered read data.
module mic_ram #(
    parameter int DEPTH = 363,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   q
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        q <= mem[addr];
    end

endmodule

FILE: sv/multicore_interrupt_controller_unit.sv
// Interrupt controller for several cores: top level and sequencer.
//
// One command channel: a word (line event, bus write or bus read) is taken at
// a rising edge with start high and busy low. Each command produces exactly
// one result word on read_data/bus_error/core_irq, marked by done for one
// cycle; the receiver cannot stall it. core_irq also shows the current
// request levels at all times.
// Setting-word reads pass from the execute state through ST_MEMRD (one port
// of the setting memory, registered read); an acknowledge goes on to ST_SCAN,
// which walks the public pending words one per cycle through the shared
// lowest-bit encoder up to the first nonzero one, then ST_PRIV checks the
// core's private word unless a public line went to core 0. Others end in ST_EXEC.
// busy stays high until the done cycle, so one command is in flight.
// After reset the setting memory, NUM_CORES*13 + distributor words (363 by
// default), is cleared one word per cycle with busy high.
module multicore_interrupt_controller_unit
    import mic_pkg::*;
#(
    parameter int NUM_CORES    = 8,
    parameter int PUBLIC_LINES = 192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic        region,
    input  logic [2:0]  core,
    input  logic [14:0] offset,
    input  logic [31:0] write_data,
    input  logic [3:0]  access_size,
    input  logic [8:0]  line,
    input  logic        level,
    output logic        done,
    output logic [31:0] read_data,
    output logic        bus_error,
    output logic [7:0]  core_irq
);

    `include "assert_macros.svh"

    localparam int PUB_WORDS  = (PUBLIC_LINES + 31) / 32;
    localparam int MAX_PUB    = 31 + PUBLIC_LINES;
    localparam int D_TYPE     = 1;
    localparam int D_CFG      = D_TYPE + PUB_WORDS;
    localparam int D_PRI      = D_CFG + (PUBLIC_LINES + 15) / 16;
    localparam int D_DEST     = D_PRI + (PUBLIC_LINES + 3) / 4;
    localparam int DIST_WORDS = D_DEST + PUBLIC_LINES;
    localparam int CORE_TOTAL = NUM_CORES * CORE_WORDS;
    localparam int DEPTH      = CORE_TOTAL + DIST_WORDS;
    localparam int AW         = $clog2(DEPTH);
    localparam int PWI        = (PUB_WORDS > 1) ? $clog2(PUB_WORDS) : 1;
    localparam int CW         = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    st_t state_reg, state_next;

    logic [1:0]  act_reg;
    logic        region_reg;
    logic [2:0]  core_reg;
    logic [14:0] off_reg;
    logic [31:0] wd_reg;
    logic [3:0]  size_reg;
    logic [8:0]  line_reg;
    logic        level_reg;

    logic [8:0]  ready_reg    [NUM_CORES];
    logic [8:0]  ready_next   [NUM_CORES];
    logic [31:0] prv_en_reg   [NUM_CORES];
    logic [31:0] prv_en_next  [NUM_CORES];
    logic [31:0] prv_pend_reg [NUM_CORES];
    logic [31:0] prv_pend_next[NUM_CORES];
    logic [31:0] prv_act_reg  [NUM_CORES];
    logic [31:0] prv_act_next [NUM_CORES];
    logic [31:0] pub_en_reg   [PUB_WORDS];
    logic [31:0] pub_en_next  [PUB_WORDS];
    logic [31:0] pub_pend_reg [PUB_WORDS];
    logic [31:0] pub_pend_next[PUB_WORDS];
    logic [31:0] pub_act_reg  [PUB_WORDS];
    logic [31:0] pub_act_next [PUB_WORDS];
    logic [NUM_CORES-1:0] req_reg, req_next;

    logic [PWI-1:0] scan_reg, scan_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic           done_reg, done_next;
    logic [31:0]    rdata_reg, rdata_next;
    logic           err_reg, err_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_q;

    logic          go_mem, go_scan;
    logic [CW-1:0] cidx;
    logic [31:0]   enc_in;
    logic [4:0]    enc;
    logic          scan_hit, scan_last;

    mic_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .q    (ram_q)
    );

    assign cidx      = core_reg[CW-1:0];
    // the shared lowest-bit encoder: public words while scanning, else private
    assign enc_in    = (state_reg == ST_SCAN) ? pub_pend_reg[scan_reg] : prv_pend_reg[cidx];
    assign enc       = low_bit(enc_in);
    assign scan_hit  = enc_in != 32'd0;
    assign scan_last = scan_reg == PWI'(PUB_WORDS - 1);

    assign busy      = state_reg != ST_IDLE;
    assign done      = done_reg;
    assign read_data = rdata_reg;
    assign bus_error = err_reg;
    assign core_irq  = 8'(req_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go_mem)
                begin
                    state_next = ST_MEMRD;
                end
                else if (go_scan)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEMRD:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_hit && ready_reg[0] == IDLE_NUM)
                begin
                    state_next = ST_IDLE;
                end
                else if (scan_hit || scan_last)
                begin
                    state_next = ST_PRIV;
                end
            end
            ST_PRIV:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic          wr;
        logic          hit;
        logic [14:0]   o;
        logic [8:0]    tgt;
        logic [8:0]    n;
        logic [8:0]    d;
        logic [8:0]    nm;
        logic [CW-1:0] ti;
        logic          en;
        logic [7:0]    grp;
        logic [7:0]    gs;
        logic [1:0]    kind;
        logic          clr;
        logic [PWI-1:0] wi;
        logic [31:0]   bm;
        logic [3:0]    slot;
        logic          is_slot;
        logic [AW-1:0] maddr;
        logic [14:0]   sub;
        logic [7:0]    num;

        ready_next    = ready_reg;
        prv_en_next   = prv_en_reg;
        prv_pend_next = prv_pend_reg;
        prv_act_next  = prv_act_reg;
        pub_en_next   = pub_en_reg;
        pub_pend_next = pub_pend_reg;
        pub_act_next  = pub_act_reg;
        req_next      = req_reg;
        scan_next     = scan_reg;
        clr_next      = clr_reg;
        done_next     = 1'b0;
        rdata_next    = rdata_reg;
        err_next      = err_reg;
        ram_we        = 1'b0;
        ram_addr      = clr_reg;
        ram_wdata     = wd_reg;
        go_mem        = 1'b0;
        go_scan       = 1'b0;

        wr      = act_reg == ACT_WRITE;
        hit     = 1'b0;
        o       = off_reg;
        tgt     = 9'd0;
        n       = line_reg;
        d       = 9'd0;
        nm      = 9'd0;
        ti      = '0;
        en      = 1'b0;
        grp     = o[14:7];
        gs      = grp - D_BM_GRP_LO;
        kind    = gs[2:1];
        clr     = gs[0];
        wi      = o[PWI+1:2];
        bm      = 32'd0;
        slot    = 4'd0;
        is_slot = 1'b0;
        maddr   = '0;
        sub     = 15'd0;
        num     = wd_reg[7:0];

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = 32'd0;
                clr_next  = clr_reg + AW'(1);
            end
            ST_EXEC:
            begin
                done_next  = 1'b1;
                rdata_next = 32'd0;
                err_next   = 1'b0;
                if (act_reg == ACT_LINE)
                begin
                    if (line_reg <= 9'(MAX_PUB))
                    begin
                        tgt = 9'd0;
                        n   = line_reg;
                    end
                    else
                    begin
                        d   = line_reg - 9'(MAX_PUB + 1);
                        tgt = 9'(d[8:4]) + 9'd1;
                        n   = 9'({1'b1, d[3:0]});
                    end
                    ti = tgt[CW-1:0];
                    nm = n - 9'd32;
                    if (tgt < 9'(NUM_CORES))
                    begin
                        if (n <= 9'd31)
                        begin
                            en = prv_en_reg[ti][n[4:0]];
                        end
                        else
                        begin
                            en = pub_en_reg[nm[PWI+4:5]][n[4:0]];
                        end
                        if (en)
                        begin
                            if (n <= 9'd31)
                            begin
                                prv_pend_next[ti][n[4:0]] = level_reg;
                            end
                            else
                            begin
                                pub_pend_next[nm[PWI+4:5]][n[4:0]] = level_reg;
                            end
                            if (level_reg && ready_reg[ti] == IDLE_NUM)
                            begin
                                ready_next[ti] = n;
                                req_next[ti]   = 1'b1;
                            end
                        end
                    end
                end
                else if (act_reg == ACT_WRITE || act_reg == ACT_READ)
                begin
                    if (o[1:0] != 2'b00)
                    begin
                        err_next = 1'b1;
                    end
                    else if (!region_reg)
                    begin
                        if (size_reg != BUS_SIZE)
                        begin
                            err_next = 1'b1;
                        end
                        else if (o == D_CTRL)
                        begin
                            hit   = 1'b1;
                            maddr = AW'(CORE_TOTAL);
                        end
                        else if (!wr && (o == D_STATUS || o == D_ID))
                        begin
                            rdata_next = 32'd0;
                        end
                        else if (in_win(o, D_TYPE_OFF, 16'(PUB_WORDS)))
                        begin
                            hit   = 1'b1;
                            sub   = o - D_TYPE_OFF;
                            maddr = AW'(CORE_TOTAL + D_TYPE) + AW'(sub[14:2]);
                        end
                        else if (in_win(o, D_CFG_OFF, 16'(D_PRI - D_CFG)))
                        begin
                            hit   = 1'b1;
                            sub   = o - D_CFG_OFF;
                            maddr = AW'(CORE_TOTAL + D_CFG) + AW'(sub[14:2]);
                        end
                        else if (in_win(o, D_PRI_OFF, 16'(D_DEST - D_PRI)))
                        begin
                            hit   = 1'b1;
                            sub   = o - D_PRI_OFF;
                            maddr = AW'(CORE_TOTAL + D_PRI) + AW'(sub[14:2]);
                        end
                        else if (in_win(o, D_DEST_OFF, 16'(PUBLIC_LINES)))
                        begin
                            hit   = 1'b1;
                            sub   = o - D_DEST_OFF;
                            maddr = AW'(CORE_TOTAL + D_DEST) + AW'(sub[14:2]);
                        end
                        else if (grp >= D_BM_GRP_LO && grp <= D_BM_GRP_HI &&
                                 5'(o[6:2]) < 5'(PUB_WORDS))
                        begin
                            case (kind)
                                BM_ENABLE:  bm = pub_en_reg[wi];
                                BM_PENDING: bm = pub_pend_reg[wi];
                                default:    bm = pub_act_reg[wi];
                            endcase
                            bm = clr ? (bm & ~wd_reg) : (bm | wd_reg);
                            if (!wr)
                            begin
                                case (kind)
                                    BM_ENABLE:  rdata_next = pub_en_reg[wi];
                                    BM_PENDING: rdata_next = pub_pend_reg[wi];
                                    default:    rdata_next = pub_act_reg[wi];
                                endcase
                            end
                            else
                            begin
                                case (kind)
                                    BM_ENABLE:  pub_en_next[wi]   = bm;
                                    BM_PENDING: pub_pend_next[wi] = bm;
                                    default:    pub_act_next[wi]  = bm;
                                endcase
                            end
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (4'(core_reg) >= 4'(NUM_CORES))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        if (o == C_CTRL)
                        begin
                            is_slot = 1'b1;
                            slot    = 4'd0;
                        end
                        else if (o == C_TYPE)
                        begin
                            is_slot = 1'b1;
                            slot    = 4'd1;
                        end
                        else if (o == C_SCFG)
                        begin
                            is_slot = 1'b1;
                            slot    = 4'd2;
                        end
                        else if (o == C_PCFG)
                        begin
                            is_slot = 1'b1;
                            slot    = 4'd3;
                        end
                        else if (in_win(o, C_SPRI, 16'd4))
                        begin
                            is_slot = 1'b1;
                            slot    = 4'd4 + 4'(o[3:2]);
                        end
                        else if (in_win(o, C_PPRI, 16'd4))
                        begin
                            is_slot = 1'b1;
                            slot    = 4'd8 + 4'(o[3:2]);
                        end
                        else if (o == C_HPPIR)
                        begin
                            is_slot = 1'b1;
                            slot    = 4'd12;
                        end

                        if (is_slot)
                        begin
                            hit   = 1'b1;
                            maddr = AW'(core_reg) * AW'(CORE_WORDS) + AW'(slot);
                        end
                        else if (o >= C_BM_LO && o <= C_BM_HI)
                        begin
                            case (o[4:3])
                                BM_ENABLE:  bm = prv_en_reg[cidx];
                                BM_PENDING: bm = prv_pend_reg[cidx];
                                default:    bm = prv_act_reg[cidx];
                            endcase
                            if (!wr)
                            begin
                                rdata_next = bm;
                            end
                            else
                            begin
                                bm = o[2] ? (bm & ~wd_reg) : (bm | wd_reg);
                                case (o[4:3])
                                    BM_ENABLE:  prv_en_next[cidx]   = bm;
                                    BM_PENDING: prv_pend_next[cidx] = bm;
                                    default:    prv_act_next[cidx]  = bm;
                                endcase
                            end
                        end
                        else if (!wr)
                        begin
                            if (o == C_ZERO_A || o == C_ZERO_B || o == C_ZERO_C ||
                                in_win(o, C_ZERO_WIN, 16'd8))
                            begin
                                rdata_next = 32'd0;
                            end
                            else if (o == C_READY)
                            begin
                                if (ready_reg[cidx] == SOFT_NUM)
                                begin
                                    prv_pend_next[cidx][15] = 1'b0;
                                end
                                rdata_next = (ready_reg[cidx] == IDLE_NUM) ? 32'hFFFF_FFFF
                                                                           : 32'(ready_reg[cidx]);
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        else if (o == C_SOFT)
                        begin
                            for (int i = 0; i < NUM_CORES; i++)
                            begin
                                if (wd_reg[8 + i])
                                begin
                                    prv_pend_next[i][15] = 1'b1;
                                    if (ready_reg[i] == IDLE_NUM)
                                    begin
                                        ready_next[i] = SOFT_NUM;
                                        req_next[i]   = 1'b1;
                                    end
                                end
                            end
                        end
                        else if (o == C_EN_NUM || o == C_DIS_NUM)
                        begin
                            nm = 9'(num) - 9'd32;
                            if (num <= 8'd31)
                            begin
                                prv_en_next[cidx][num[4:0]] = (o == C_EN_NUM);
                            end
                            else if (9'(num) <= 9'(MAX_PUB))
                            begin
                                pub_en_next[nm[PWI+4:5]][num[4:0]] = (o == C_EN_NUM);
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        else if (o == C_ACK)
                        begin
                            ready_next[cidx] = IDLE_NUM;
                            req_next[cidx]   = 1'b0;
                            scan_next        = '0;
                            go_scan          = 1'b1;
                            done_next        = 1'b0;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end

                    if (hit)
                    begin
                        ram_addr = maddr;
                        ram_we   = wr;
                        if (!wr)
                        begin
                            go_mem    = 1'b1;
                            done_next = 1'b0;
                        end
                    end
                    if (wr)
                    begin
                        rdata_next = 32'd0;
                    end
                end
            end
            ST_MEMRD:
            begin
                done_next  = 1'b1;
                rdata_next = ram_q;
            end
            ST_SCAN:
            begin
                if (scan_hit && ready_reg[0] == IDLE_NUM)
                begin
                    ready_next[0] = 9'd32 + 9'({scan_reg, enc});
                    req_next[0]   = 1'b1;
                    done_next     = 1'b1;
                end
                else if (!scan_hit && !scan_last)
                begin
                    scan_next = scan_reg + PWI'(1);
                end
            end
            ST_PRIV:
            begin
                done_next = 1'b1;
                if (scan_hit)
                begin
                    ready_next[cidx] = 9'(enc);
                    req_next[cidx]   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            scan_reg  <= '0;
            done_reg  <= 1'b0;
            req_reg   <= '0;
            for (int i = 0; i < NUM_CORES; i++)
            begin
                ready_reg[i]    <= IDLE_NUM;
                prv_en_reg[i]   <= 32'd0;
                prv_pend_reg[i] <= 32'd0;
                prv_act_reg[i]  <= 32'd0;
            end
            for (int i = 0; i < PUB_WORDS; i++)
            begin
                pub_en_reg[i]   <= 32'd0;
                pub_pend_reg[i] <= 32'd0;
                pub_act_reg[i]  <= 32'd0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            scan_reg     <= scan_next;
            done_reg     <= done_next;
            req_reg      <= req_next;
            ready_reg    <= ready_next;
            prv_en_reg   <= prv_en_next;
            prv_pend_reg <= prv_pend_next;
            prv_act_reg  <= prv_act_next;
            pub_en_reg   <= pub_en_next;
            pub_pend_reg <= pub_pend_next;
            pub_act_reg  <= pub_act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        err_reg   <= err_next;
        if (state_reg == ST_IDLE && start)
        begin
            act_reg    <= action;
            region_reg <= region;
            core_reg   <= core;
            off_reg    <= offset;
            wd_reg     <= write_data;
            size_reg   <= access_size;
            line_reg   <= line;
            level_reg  <= level;
        end
    end

    `MIC_ASSERT(a_done_after_work, done |-> $past(busy))
    `MIC_ASSERT(a_err_zero_data, (done && bus_error) |-> (read_data == 32'd0))
    `MIC_ASSERT(a_req_tracks_ready, (ready_reg[0] == IDLE_NUM) |-> !core_irq[0])
    `MIC_ASSERT(a_scan_in_range, (state_reg == ST_SCAN) |-> (scan_reg <= PWI'(PUB_WORDS - 1)))
    `MIC_ASSERT_ALWAYS(a_no_irq_in_reset, !rst_n |-> ##1 (!rst_n |-> core_irq == 8'd0))

endmodule

FILE: dv/tb_top.sv
// Testbench for the multicore interrupt controller: directed table, then random words.
module tb_top;
    import mic_pkg::*;

    localparam int NCORE     = 8;
    localparam int PUB_W     = 6;
    localparam int DIST_N    = 259;
    localparam int CW_N      = NCORE * CORE_WORDS;
    localparam int LAST_PUB  = 223;
    localparam int CYC_LIMIT = 400000;
    localparam int N_RANDOM  = 1200;

    typedef struct packed {
        logic [1:0]  act;
        logic        rgn;
        logic [2:0]  cid;
        logic [14:0] off;
        logic [31:0] wd;
        logic [3:0]  size;
        logic [8:0]  lnum;
        logic        lvl;
    } cmd_t;

    typedef struct packed {
        logic [31:0] rd;
        logic        err;
        logic [7:0]  irq;
    } res_t;

    typedef struct packed {
        cmd_t c;
        logic typed;
        res_t r;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic        region;
    logic [2:0]  core;
    logic [14:0] offset;
    logic [31:0] write_data;
    logic [3:0]  access_size;
    logic [8:0]  line;
    logic        level;
    logic        done;
    logic [31:0] read_data;
    logic        bus_error;
    logic [7:0]  core_irq;

    multicore_interrupt_controller_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .region(region), .core(core), .offset(offset),
        .write_data(write_data), .access_size(access_size), .line(line),
        .level(level), .done(done), .read_data(read_data),
        .bus_error(bus_error), .core_irq(core_irq)
    );

    // controller state mirror
    logic [8:0]  rdy_num  [NCORE];
    logic [31:0] prv_en   [NCORE];
    logic [31:0] prv_pend [NCORE];
    logic [31:0] prv_act  [NCORE];
    logic [31:0] pub_en   [PUB_W];
    logic [31:0] pub_pend [PUB_W];
    logic [31:0] pub_act  [PUB_W];
    logic [7:0]  irq_lvl;
    logic [31:0] core_words [CW_N];
    logic [31:0] dist_words [DIST_N];

    res_t results_due[$];
    int   n_fail;
    int   cyc;
    int   idle_pct;

    initial begin
        clk = 1'b0;
        forever
        begin
            #1 clk = 1'b1;
            #1 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit span(input int unsigned o, input int unsigned base,
                                input int unsigned n);
        return o >= base && (o - base) / 4 < n;
    endfunction

    function automatic int unsigned first_set(input logic [31:0] v);
        int unsigned k;
        k = 0;
        while (k < 31 && !v[k])
            k++;
        return k;
    endfunction

    function automatic void latch_irq(input int unsigned c, input int unsigned n);
        rdy_num[c] = 9'(n);
        irq_lvl[c] = 1'b1;
    endfunction

    function automatic void line_change(input int unsigned ln, input bit lv);
        int unsigned tgt, n, w;
        bit          en, pend_busy;
        if (ln <= LAST_PUB)
        begin
            tgt = 0;
            n   = ln;
        end
        else
        begin
            tgt = (ln - LAST_PUB - 1) / 16 + 1;
            n   = (ln - LAST_PUB - 1) % 16 + 16;
        end
        if (tgt >= NCORE)
            return;
        w  = (n - 32) / 32;
        en = (n <= 31) ? prv_en[tgt][n] : pub_en[w][n % 32];
        if (!en)
            return;
        pend_busy = rdy_num[tgt] != IDLE_NUM;
        if (n <= 31)
            prv_pend[tgt][n] = lv;
        else
            pub_pend[w][n % 32] = lv;
        if (lv && !pend_busy)
            latch_irq(tgt, n);
    endfunction

    function automatic void take_ack(input int unsigned c);
        bit hit;
        rdy_num[c] = IDLE_NUM;
        irq_lvl[c] = 1'b0;
        hit = 1'b0;
        for (int i = 0; i < PUB_W; i++)
        begin
            if (!hit && pub_pend[i] != 0)
            begin
                hit = 1'b1;
                if (rdy_num[0] == IDLE_NUM)
                begin
                    latch_irq(0, 32 + 32 * i + first_set(pub_pend[i]));
                    return;
                end
            end
        end
        if (prv_pend[c] != 0)
            latch_irq(c, first_set(prv_pend[c]));
    endfunction

    function automatic bit dist_rw(input bit wr, input int unsigned o, input logic [31:0] v,
                                   inout logic [31:0] rd);
        int unsigned idx, kind, w;
        if (o == 0)
        begin
            if (wr) dist_words[0] = v; else rd = dist_words[0];
            return 0;
        end
        if (!wr && (o == 'h8 || o == 'h10))
        begin
            rd = 0;
            return 0;
        end
        if (span(o, 'h80, 6) || span(o, 'h100, 12) || span(o, 'h200, 48) ||
            span(o, 'h1000, 192))
        begin
            if (o >= 'h1000) idx = 67 + (o - 'h1000) / 4;
            else if (o >= 'h200) idx = 19 + (o - 'h200) / 4;
            else if (o >= 'h100) idx = 7 + (o - 'h100) / 4;
            else idx = 1 + (o - 'h80) / 4;
            if (wr) dist_words[idx] = v; else rd = dist_words[idx];
            return 0;
        end
        // six bitmap windows of 0x80 bytes from 0x600: enable, pending, active; set then clear
        if (o < 'h600 || o >= 'h900 || (o % 'h80) / 4 >= PUB_W)
            return 1;
        kind = (o - 'h600) / 'h80;
        w    = (o % 'h80) / 4;
        if (!wr)
        begin
            rd = (kind / 2 == 0) ? pub_en[w] : (kind / 2 == 1) ? pub_pend[w] : pub_act[w];
            return 0;
        end
        case (kind)
            0: pub_en[w]   |= v;
            1: pub_en[w]   &= ~v;
            2: pub_pend[w] |= v;
            3: pub_pend[w] &= ~v;
            4: pub_act[w]  |= v;
            default: pub_act[w] &= ~v;
        endcase
        return 0;
    endfunction

    function automatic bit en_by_num(input int unsigned c, input logic [31:0] v, input bit set);
        int unsigned n;
        n = v[7:0];
        if (n <= 31)
            prv_en[c][n] = set;
        else if (n <= LAST_PUB)
            pub_en[(n - 32) / 32][n % 32] = set;
        else
            return 1;
        return 0;
    endfunction

    function automatic bit core_rw(input bit wr, input int unsigned c, input int unsigned o,
                                   input logic [31:0] v, inout logic [31:0] rd);
        int          slot;
        int unsigned b;
        slot = -1;
        b    = c * CORE_WORDS;
        if (o == C_CTRL) slot = 0;
        else if (o == C_TYPE) slot = 1;
        else if (o == C_SCFG) slot = 2;
        else if (o == C_PCFG) slot = 3;
        else if (span(o, C_SPRI, 4)) slot = 4 + (o - C_SPRI) / 4;
        else if (span(o, C_PPRI, 4)) slot = 8 + (o - C_PPRI) / 4;
        else if (o == C_HPPIR) slot = 12;
        if (slot >= 0)
        begin
            if (wr) core_words[b + slot] = v; else rd = core_words[b + slot];
            return 0;
        end
        if (o >= C_BM_LO && o <= C_BM_HI)
        begin
            if (!wr)
                rd = (o < 'h48) ? prv_en[c] : (o < 'h50) ? prv_pend[c] : prv_act[c];
            else if (o < 'h48)
                prv_en[c] = o[2] ? prv_en[c] & ~v : prv_en[c] | v;
            else if (o < 'h50)
                prv_pend[c] = o[2] ? prv_pend[c] & ~v : prv_pend[c] | v;
            else
                prv_act[c] = o[2] ? prv_act[c] & ~v : prv_act[c] | v;
            return 0;
        end
        if (!wr)
        begin
            if (o == C_ZERO_A || o == C_ZERO_B || o == C_ZERO_C || span(o, C_ZERO_WIN, 8))
            begin
                rd = 0;
                return 0;
            end
            if (o == C_READY)
            begin
                if (rdy_num[c] == SOFT_NUM)
                    prv_pend[c][15] = 1'b0;
                rd = (rdy_num[c] == IDLE_NUM) ? 32'hFFFF_FFFF : 32'(rdy_num[c]);
                return 0;
            end
            return 1;
        end
        if (o == C_SOFT)
        begin
            for (int i = 0; i < NCORE; i++)
            begin
                if (v[8 + i])
                begin
                    prv_pend[i][15] = 1'b1;
                    if (rdy_num[i] == IDLE_NUM)
                        latch_irq(i, SOFT_NUM);
                end
            end
            return 0;
        end
        if (o == C_EN_NUM) return en_by_num(c, v, 1'b1);
        if (o == C_DIS_NUM) return en_by_num(c, v, 1'b0);
        if (o == C_ACK)
        begin
            take_ack(c);
            return 0;
        end
        return 1;
    endfunction

    function automatic res_t irq_step(input cmd_t c);
        res_t r;
        bit   wr;
        r.rd  = 0;
        r.err = 1'b0;
        wr    = c.act == ACT_WRITE;
        if (c.act == ACT_LINE)
            line_change(c.lnum, c.lvl);
        else if (c.act == ACT_WRITE || c.act == ACT_READ)
        begin
            if (c.off[1:0] != 0)
                r.err = 1'b1;
            else if (!c.rgn)
                r.err = (c.size != BUS_SIZE) ? 1'b1 : dist_rw(wr, c.off, c.wd, r.rd);
            else
                r.err = core_rw(wr, c.cid, c.off, c.wd, r.rd);
            if (r.err || wr)
                r.rd = 0;
        end
        r.irq = irq_lvl;
        return r;
    endfunction

    // drive one word, hold it until taken, queue what it should return
    task automatic send(input cmd_t c, input bit typed, input res_t given);
        res_t r;
        @(negedge clk);
        start       = 1'b1;
        action      = c.act;
        region      = c.rgn;
        core        = c.cid;
        offset      = c.off;
        write_data  = c.wd;
        access_size = c.size;
        line        = c.lnum;
        level       = c.lvl;
        do
            @(posedge clk);
        while (busy);
        r = irq_step(c);
        results_due.push_back(typed ? given : r);
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected word: rd=%h err=%b irq=%h", read_data, bus_error,
                             core_irq);
            end
            else
            begin
                want = results_due.pop_front();
                if (want.rd !== read_data || want.err !== bus_error || want.irq !== core_irq)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: exp rd=%h err=%b irq=%h got rd=%h err=%b irq=%h",
                                 want.rd, want.err, want.irq, read_data, bus_error, core_irq);
                end
            end
        end
    end

    function automatic cmd_t rand_cmd();
        cmd_t        c;
        int unsigned pick;
        c.act  = ACT_READ;
        c.rgn  = 1'b1;
        c.cid  = 3'($urandom_range(NCORE - 1));
        c.off  = 15'(4 * $urandom_range(47));
        c.wd   = $urandom();
        c.size = ($urandom_range(3) == 0) ? 4'($urandom_range(1, 8)) : BUS_SIZE;
        c.lnum = 9'($urandom_range(LAST_PUB + 224));
        c.lvl  = 1'($urandom_range(1));
        if ($urandom_range(1)) c.act = ACT_WRITE;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            c.act = ACT_LINE;
            // keep most events on low public and private lines that are likely enabled
            if ($urandom_range(1)) c.lnum = 9'($urandom_range(63));
            else if ($urandom_range(1)) c.lnum = 9'($urandom_range(224, 335));
            if ($urandom_range(2) != 0) c.lvl = 1'b1;
        end
        else if (pick < 44)
        begin
            c.act = ACT_WRITE;
            c.off = ($urandom_range(4) == 0) ? C_DIS_NUM : C_EN_NUM;
            c.wd[7:0] = ($urandom_range(9) == 0) ? 8'($urandom_range(224, 255))
                      : ($urandom_range(1) ? 8'($urandom_range(63)) : 8'($urandom_range(223)));
        end
        else if (pick < 54)
        begin
            c.act = ACT_WRITE;
            c.off = C_ACK;
        end
        else if (pick < 64)
        begin
            c.act = ACT_READ;
            c.off = C_READY;
        end
        else if (pick < 68)
        begin
            c.act = ACT_WRITE;
            c.off = C_SOFT;
        end
        else if (pick < 88)
        begin
            c.rgn = 1'b0;
            case ($urandom_range(6))
                0: c.off = 15'(4 * $urandom_range(5));
                1: c.off = 15'('h80 + 4 * $urandom_range(7));
                2: c.off = 15'('h100 + 4 * $urandom_range(13));
                3: c.off = 15'('h200 + 4 * $urandom_range(49));
                4: c.off = 15'('h1000 + 4 * $urandom_range(193));
                default: c.off = 15'('h600 + 'h80 * $urandom_range(5) + 4 * $urandom_range(6));
            endcase
        end
        else if (pick < 94)
        begin
            c.rgn = 1'($urandom_range(1));
            c.off = 15'($urandom_range(32767));
            c.act = 2'($urandom_range(3));
        end
        return c;
    endfunction

    initial
    begin
        row_t  tbl [24];
        res_t  none;
        cmd_t  c;
        int    settle;
        none = '0;
        tbl = '{
            // reset values, decode errors
            '{'{ACT_READ,  1'b0, 3'd0, D_CTRL,     32'h0,      4'd4, 9'd0,   1'b0}, 1'b1,
              '{32'h0, 1'b0, 8'h00}},
            '{'{ACT_READ,  1'b1, 3'd0, C_READY,    32'h0,      4'd1, 9'd0,   1'b0}, 1'b1,
              '{32'hFFFF_FFFF, 1'b0, 8'h00}},
            '{'{ACT_WRITE, 1'b0, 3'd0, 15'h0002,   32'h5,      4'd4, 9'd0,   1'b0}, 1'b1,
              '{32'h0, 1'b1, 8'h00}},
            '{'{ACT_READ,  1'b0, 3'd0, D_CTRL,     32'h0,      4'd8, 9'd0,   1'b0}, 1'b1,
              '{32'h0, 1'b1, 8'h00}},
            '{'{ACT_READ,  1'b0, 3'd0, 15'h4000,   32'h0,      4'd4, 9'd0,   1'b0}, 1'b1,
              '{32'h0, 1'b1, 8'h00}},
            '{'{ACT_WRITE, 1'b1, 3'd3, C_EN_NUM,   32'hFF,     4'd4, 9'd0,   1'b0}, 1'b1,
              '{32'h0, 1'b1, 8'h00}},
            '{'{ACT_WRITE, 1'b1, 3'd7, 15'h00a8,   32'h0,      4'd2, 9'd0,   1'b0}, 1'b1,
              '{32'h0, 1'b1, 8'h00}},
            '{'{ACT_READ,  1'b1, 3'd1, 15'h7ffc,   32'h0,      4'd4, 9'd0,   1'b0}, 1'b1,
              '{32'h0, 1'b1, 8'h00}},
            // public line through to acknowledge
            '{'{ACT_WRITE, 1'b1, 3'd0, C_EN_NUM,   32'd40,     4'd4, 9'd0,   1'b0}, 1'b0, none},
            '{'{ACT_LINE,  1'b0, 3'd0, 15'h0,      32'h0,      4'd4, 9'd40,  1'b1}, 1'b0, none},
            '{'{ACT_READ,  1'b1, 3'd0, C_READY,    32'h0,      4'd4, 9'd0,   1'b0}, 1'b0, none},
            '{'{ACT_LINE,  1'b0, 3'd0, 15'h0,      32'h0,      4'd4, 9'd40,  1'b0}, 1'b0, none},
            '{'{ACT_WRITE, 1'b1, 3'd0, C_ACK,      32'h0,      4'd4, 9'd0,   1'b0}, 1'b0, none},
            // software interrupt to every core, ready read clears it
            '{'{ACT_WRITE, 1'b1, 3'd5, C_SOFT,     32'hFFFF_FF00, 4'd4, 9'd0, 1'b0}, 1'b0, none},
            '{'{ACT_READ,  1'b1, 3'd2, C_READY,    32'h0,      4'd4, 9'd0,   1'b0}, 1'b0, none},
            '{'{ACT_READ,  1'b1, 3'd2, 15'h48,     32'h0,      4'd4, 9'd0,   1'b0}, 1'b0, none},
            '{'{ACT_WRITE, 1'b1, 3'd2, C_ACK,      32'h0,      4'd4, 9'd0,   1'b0}, 1'b0, none},
            // line beyond the last core is dropped
            '{'{ACT_LINE,  1'b1, 3'd7, 15'h7fff,   32'hFFFF_FFFF, 4'd15, 9'd447, 1'b1}, 1'b0, none},
            // setting words at the window ends
            '{'{ACT_WRITE, 1'b0, 3'd0, D_CTRL,     32'hFFFF_FFFF, 4'd4, 9'd0, 1'b0}, 1'b0, none},
            '{'{ACT_WRITE, 1'b0, 3'd0, 15'h12fc,   32'hA5A5_5A5A, 4'd4, 9'd0, 1'b0}, 1'b0, none},
            '{'{ACT_READ,  1'b0, 3'd0, 15'h12fc,   32'h0,      4'd4, 9'd0,   1'b0}, 1'b0, none},
            // top public pending bit picked up by the rescan
            '{'{ACT_WRITE, 1'b0, 3'd0, 15'h0714,   32'h8000_0000, 4'd4, 9'd0, 1'b0}, 1'b0, none},
            '{'{ACT_WRITE, 1'b1, 3'd0, C_ACK,      32'h0,      4'd4, 9'd0,   1'b0}, 1'b0, none},
            '{'{ACT_READ,  1'b0, 3'd0, 15'h0894,   32'h0,      4'd4, 9'd0,   1'b0}, 1'b0, none}
        };

        for (int i = 0; i < NCORE; i++)
        begin
            rdy_num[i]  = IDLE_NUM;
            prv_en[i]   = 0;
            prv_pend[i] = 0;
            prv_act[i]  = 0;
        end
        for (int i = 0; i < PUB_W; i++)
        begin
            pub_en[i]   = 0;
            pub_pend[i] = 0;
            pub_act[i]  = 0;
        end
        for (int i = 0; i < CW_N; i++)
            core_words[i] = 0;
        for (int i = 0; i < DIST_N; i++)
            dist_words[i] = 0;
        irq_lvl     = 0;
        idle_pct    = 13;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_LINE;
        region      = 1'b0;
        core        = 3'd0;
        offset      = 15'd0;
        write_data  = 32'd0;
        access_size = BUS_SIZE;
        line        = 9'd0;
        level       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (tbl[i])
            send(tbl[i].c, tbl[i].typed, tbl[i].r);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3) idle_pct = 82;
            if (n == 2 * N_RANDOM / 3) idle_pct = 0;
            if (n == N_RANDOM / 2)
            begin
                // drain everything before going on
                @(negedge clk);
                start = 1'b0;
                while (results_due.size() != 0)
                    @(negedge clk);
            end
            c = rand_cmd();
            send(c, 1'b0, none);
        end

        @(negedge clk);
        start = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        settle = PUB_W + 6;
        repeat (settle) @(posedge clk);
        if (n_fail == 0 && results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: files.f
+incdir+sv
sv/mic_pkg.sv
sv/mic_ram.sv
sv/multicore_interrupt_controller_unit.sv
dv/tb_top.sv
